// ===== hdl/ppgd_pkg.sv =====
`default_nettype none

package ppgd_pkg;

  // Table geometry
  localparam int unsigned SINE_DEPTH   = 1024;
  localparam int unsigned DITHER_DEPTH = 256;
  localparam int unsigned SINE_AW      = $clog2(SINE_DEPTH);
  localparam int unsigned DITHER_AW    = $clog2(DITHER_DEPTH);

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COORD_W = 9;
  localparam int unsigned FRAME_W = 12;
  localparam int unsigned PIXEL_W = 16;
  localparam int unsigned FADE_W  = 7;

  // Item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_SINE   = 2'd0,
    OP_LOAD_DITHER = 2'd1,
    OP_RENDER      = 2'd2
  } op_e;

  // Fade and saturation constants
  localparam logic [FRAME_W-1:0] FADE_IN_END    = 12'd64;
  localparam logic [FRAME_W-1:0] FADE_OUT_START = 12'd192;
  localparam logic [FRAME_W-1:0] SHIFT2_START   = 12'd256;
  localparam logic [FADE_W-1:0]  FADE_OUT_BASE  = 7'd32;
  localparam logic [BYTE_W-1:0]  RB_SAT         = 8'd249;
  localparam logic [BYTE_W-1:0]  G_SAT          = 8'd253;

endpackage

`default_nettype wire

// ===== hdl/plasma_pixel_generator_dithered.sv =====
// A render item passes through the stage 1, 2 and 3 registers and then the output register.
// One item per cycle unless stalled, loads and renders alike; stages advance independently.
// Sine store is held in three written-together copies so six reads fit each cycle.
// Reset clears the stage valid bits only; sine and dither tables are undefined until loaded.
// A load waits until any older render has issued its nested sine read.
`default_nettype none

module plasma_pixel_generator_dithered (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [ppgd_pkg::OP_W-1:0]      op_i,
  input  wire logic [ppgd_pkg::SINE_AW-1:0]   table_index_i,
  input  wire logic [ppgd_pkg::BYTE_W-1:0]    table_value_i,
  input  wire logic [ppgd_pkg::COORD_W-1:0]   pixel_x_i,
  input  wire logic [ppgd_pkg::COORD_W-1:0]   pixel_y_i,
  input  wire logic [ppgd_pkg::FRAME_W-1:0]   frame_number_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [ppgd_pkg::PIXEL_W-1:0]        pixel_color_o
);
  import ppgd_pkg::*;

  // Memories
  logic [BYTE_W-1:0] sine_a_mem [SINE_DEPTH];
  logic [BYTE_W-1:0] sine_b_mem [SINE_DEPTH];
  logic [BYTE_W-1:0] sine_c_mem [SINE_DEPTH];
  logic [BYTE_W-1:0] dither_mem [DITHER_DEPTH];

  // Handshake and stage control
  logic in_fire, sine_we, dither_we;
  logic s1_v_q, s1_v_d, s2_v_q, s2_v_d, s3_v_q, s3_v_d, out_v_q, out_v_d;
  logic s1_free, s2_free, s3_free, out_free;
  logic s1_load, s2_load, s3_load, out_load;

  assign out_free   = !out_v_q || out_ready_i;
  assign s3_free    = !s3_v_q || out_free;
  assign s2_free    = !s2_v_q || s3_free;
  assign s1_free    = !s1_v_q || s2_free;
  assign in_ready_o = s1_free;

  assign in_fire   = in_valid_i && in_ready_o;
  assign sine_we   = in_fire && (op_i == OP_LOAD_SINE);
  assign dither_we = in_fire && (op_i == OP_LOAD_DITHER);
  assign s1_load   = in_fire && (op_i == OP_RENDER);
  assign s2_load   = s1_v_q && s2_free;
  assign s3_load   = s2_v_q && s3_free;
  assign out_load  = s3_v_q && out_free;

  // Stage 0: address generation from the item fields
  logic [SINE_AW-1:0]   ar_addr, ab_addr, ir_addr, ib_addr, ir_base, ib_base;
  logic [SINE_AW-1:0]   f7_d, f2_d;
  logic [DITHER_AW-1:0] d_addr;
  logic [FADE_W-1:0]    mul_d;
  logic                 fade_en_d, shift2_d;
  logic [8:0]           fade_rem;

  always_comb begin
    ar_addr = SINE_AW'({pixel_x_i, 2'b00}) + SINE_AW'({pixel_y_i, 1'b0})
            + SINE_AW'({frame_number_i, 2'b00});
    ab_addr = SINE_AW'(pixel_x_i) + SINE_AW'({pixel_y_i, 2'b00})
            + SINE_AW'({frame_number_i, 1'b0});
    ir_base = SINE_AW'({pixel_y_i, 1'b0}) + SINE_AW'(frame_number_i);
    ir_addr = {ir_base[SINE_AW-2:0], 1'b0} + SINE_AW'(pixel_x_i);
    ib_base = SINE_AW'({pixel_x_i, 1'b0}) + SINE_AW'(frame_number_i);
    ib_addr = {ib_base[SINE_AW-2:0], 1'b0} + SINE_AW'(pixel_y_i);
    f7_d    = SINE_AW'({frame_number_i, 3'b000}) - SINE_AW'(frame_number_i);
    f2_d    = SINE_AW'({frame_number_i, 1'b0});
    d_addr  = DITHER_AW'({pixel_y_i, 4'b0000}) + DITHER_AW'(pixel_x_i);
  end

  // Pick the fade factor for the frame
  always_comb begin
    fade_rem = 9'd256 - frame_number_i[8:0];
    shift2_d = (frame_number_i >= SHIFT2_START);
    if (frame_number_i < FADE_IN_END) begin
      fade_en_d = 1'b1;
      mul_d     = FADE_W'(frame_number_i[5:0]);
    end else if (frame_number_i > FADE_OUT_START && frame_number_i < SHIFT2_START) begin
      fade_en_d = 1'b1;
      mul_d     = FADE_OUT_BASE + FADE_W'(fade_rem[8:2]);
    end else begin
      fade_en_d = 1'b0;
      mul_d     = '0;
    end
  end

  // Stage 1 payload: direct and inner sine reads, dither read, frame terms
  logic [BYTE_W-1:0]    s1_ar_q, s1_ab_q, s1_ir_q, s1_ib_q, s1_d_q;
  logic [SINE_AW-1:0]   s1_f7_q, s1_f2_q;
  logic [FADE_W-1:0]    s1_mul_q;
  logic                 s1_fade_q, s1_shift2_q;

  // Copy A serves the direct reads; write the load alongside
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_ar_q <= sine_a_mem[ar_addr];
      s1_ab_q <= sine_a_mem[ab_addr];
    end
    if (sine_we) sine_a_mem[table_index_i] <= table_value_i;
  end

  // Copy B serves the inner reads of the nested terms
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_ir_q <= sine_b_mem[ir_addr];
      s1_ib_q <= sine_b_mem[ib_addr];
    end
    if (sine_we) sine_b_mem[table_index_i] <= table_value_i;
  end

  // Dither table
  always_ff @(posedge clk_i) begin
    if (s1_load) s1_d_q <= dither_mem[d_addr];
    if (dither_we) dither_mem[table_index_i[DITHER_AW-1:0]] <= table_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_f7_q     <= f7_d;
      s1_f2_q     <= f2_d;
      s1_mul_q    <= mul_d;
      s1_fade_q   <= fade_en_d;
      s1_shift2_q <= shift2_d;
    end
  end

  // Stage 1 to 2: nested reads from copy C (read-first against a same-cycle load)
  logic [SINE_AW-1:0] nr_addr, nb_addr;
  logic [BYTE_W-1:0]  s2_nr_q, s2_nb_q, s2_ar_q, s2_ab_q, s2_d_q;
  logic [FADE_W-1:0]  s2_mul_q;
  logic               s2_fade_q, s2_shift2_q;

  assign nr_addr = SINE_AW'(s1_ir_q) + s1_f7_q;
  assign nb_addr = SINE_AW'(s1_ib_q) + s1_f2_q;

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_nr_q <= sine_c_mem[nr_addr];
      s2_nb_q <= sine_c_mem[nb_addr];
    end
    if (sine_we) sine_c_mem[table_index_i] <= table_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_ar_q     <= s1_ar_q;
      s2_ab_q     <= s1_ab_q;
      s2_d_q      <= s1_d_q;
      s2_mul_q    <= s1_mul_q;
      s2_fade_q   <= s1_fade_q;
      s2_shift2_q <= s1_shift2_q;
    end
  end

  // Stage 2: sum, shift and fade each of red and blue
  logic [BYTE_W:0]     sum_r, sum_b;
  logic [BYTE_W-1:0]   sh_r, sh_b, pr_d, pb_d;
  logic [14:0]         prod_r, prod_b;

  always_comb begin
    sum_r  = {1'b0, s2_ar_q} + {1'b0, s2_nr_q};
    sum_b  = {1'b0, s2_ab_q} + {1'b0, s2_nb_q};
    sh_r   = s2_shift2_q ? {1'b0, sum_r[BYTE_W:2]} : sum_r[BYTE_W:1];
    sh_b   = s2_shift2_q ? {1'b0, sum_b[BYTE_W:2]} : sum_b[BYTE_W:1];
    prod_r = 15'(sh_r) * 15'(s2_mul_q);
    prod_b = 15'(sh_b) * 15'(s2_mul_q);
    pr_d   = s2_fade_q ? prod_r[13:6] : sh_r;
    pb_d   = s2_fade_q ? prod_b[13:6] : sh_b;
  end

  logic [BYTE_W-1:0] s3_pr_q, s3_pb_q, s3_d_q;

  always_ff @(posedge clk_i) begin
    if (s3_load) begin
      s3_pr_q <= pr_d;
      s3_pb_q <= pb_d;
      s3_d_q  <= s2_d_q;
    end
  end

  // Stage 3: green average, dither, pack RGB565
  logic [BYTE_W-1:0]  cg, cr_dt, cg_dt, cb_dt;
  logic [PIXEL_W-1:0] pixel_d;

  always_comb begin
    cg    = {1'b0, s3_pr_q[BYTE_W-1:1]} + {1'b0, s3_pb_q[BYTE_W-1:1]};
    cr_dt = (s3_pr_q < RB_SAT) ? s3_pr_q + BYTE_W'(s3_d_q[2:0]) : s3_pr_q;
    cg_dt = (cg < G_SAT)       ? cg + BYTE_W'(s3_d_q[4:3])      : cg;
    cb_dt = (s3_pb_q < RB_SAT) ? s3_pb_q + BYTE_W'(s3_d_q[7:5]) : s3_pb_q;
    pixel_d = {cr_dt[7:3], cg_dt[7:2], cb_dt[7:3]};
  end

  logic [PIXEL_W-1:0] pixel_q;

  always_ff @(posedge clk_i) begin
    if (out_load) pixel_q <= pixel_d;
  end

  assign pixel_color_o = pixel_q;
  assign out_valid_o   = out_v_q;

  // Advance stage valid bits
  always_comb begin
    s1_v_d = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_v_q);
    s2_v_d = s2_load ? 1'b1 : (s3_load ? 1'b0 : s2_v_q);
    s3_v_d = s3_load ? 1'b1 : (out_load ? 1'b0 : s3_v_q);
    out_v_d = out_load ? 1'b1 : ((out_v_q && out_ready_i) ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      s3_v_q  <= s3_v_d;
      out_v_q <= out_v_d;
    end
  end

`ifndef SYNTHESIS
  a_render_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load |=> s1_v_q)
    else $error("render item did not enter stage 1");

  a_load_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i != OP_RENDER) |=> !s1_v_q)
    else $error("table load occupied a pipeline slot");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s2_free) |=> (s1_v_q && $stable(s1_ir_q) && $stable(s1_ib_q)))
    else $error("stalled stage 1 lost its inner sine reads");

  a_nested_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s2_free) |-> !in_ready_o)
    else $error("item accepted while nested read pending");

  a_stage3_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_v_q)
    else $error("pixel lost on its way to the output register");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_plasma_pixel_generator_dithered.sv =====
module tb_plasma_pixel_generator_dithered;
  import ppgd_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SINE_AW-1:0] idx;
    logic [BYTE_W-1:0]  val;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [FRAME_W-1:0] frame;
  } plasma_item_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [OP_W-1:0]     op_i = OP_RESERVED;
  logic [SINE_AW-1:0]  table_index_i = '0;
  logic [BYTE_W-1:0]   table_value_i = '0;
  logic [COORD_W-1:0]  pixel_x_i = '0;
  logic [COORD_W-1:0]  pixel_y_i = '0;
  logic [FRAME_W-1:0]  frame_number_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [PIXEL_W-1:0]  pixel_color_o;

  // Copies of the tables as the block should hold them
  logic [BYTE_W-1:0] sine_bytes [SINE_DEPTH];
  logic [BYTE_W-1:0] dither_bytes [DITHER_DEPTH];

  plasma_item_t       pending_items [$];
  logic [PIXEL_W-1:0] expected_pixels [$];
  plasma_item_t       drive_item;

  int unsigned total_items = 0;
  int unsigned items_accepted = 0;
  int unsigned pixels_checked = 0;
  int unsigned sine_loads = 0;
  int unsigned dither_loads = 0;
  int unsigned reserved_items = 0;
  int unsigned skip_pixels = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned mode_left = 0;
  int unsigned rx_phase = 0;
  int unsigned idle_cycles = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;

  plasma_pixel_generator_dithered i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .frame_number_i (frame_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_color_o  (pixel_color_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Compute one plasma pixel from the table copies; flag a near-full-scale skip
  function automatic logic [PIXEL_W-1:0] plasma_pixel(input int unsigned x,
                                                      input int unsigned y,
                                                      input int unsigned f,
                                                      output bit skipped);
    int unsigned shift, pr, pb, cr, cg, cb, fade;
    logic [BYTE_W-1:0] d;
    shift = (f < SHIFT2_START) ? 1 : 2;
    pr = sine_bytes[SINE_AW'((x << 2) + (y << 1) + (f << 2))];
    pr += sine_bytes[SINE_AW'(sine_bytes[SINE_AW'((((y << 1) + f) << 1) + x)] + f * 7)];
    pr >>= shift;
    pb = sine_bytes[SINE_AW'(x + (y << 2) + (f << 1))];
    pb += sine_bytes[SINE_AW'(sine_bytes[SINE_AW'((((x << 1) + f) << 1) + y)] + (f << 1))];
    pb >>= shift;
    // Fade in over the first frames, fade out just before the shift change
    if (f < FADE_IN_END) begin
      pr = (pr * f) >> 6;
      pb = (pb * f) >> 6;
    end else if (f > FADE_OUT_START && f < SHIFT2_START) begin
      fade = FADE_OUT_BASE + ((SHIFT2_START - f) >> 2);
      pr = (pr * fade) >> 6;
      pb = (pb * fade) >> 6;
    end
    cr = pr & 8'hff;
    cg = ((pr >> 1) + (pb >> 1)) & 8'hff;
    cb = pb & 8'hff;
    // Add dither bits unless the channel is near full scale
    d = dither_bytes[DITHER_AW'((y << 4) + x)];
    skipped = 1'b0;
    if (cr < RB_SAT) cr += d[2:0];
    else skipped = 1'b1;
    if (cg < G_SAT) cg += d[4:3];
    else skipped = 1'b1;
    if (cb < RB_SAT) cb += d[7:5];
    else skipped = 1'b1;
    return {5'(cr >> 3), 6'(cg >> 2), 5'(cb >> 3)};
  endfunction

  // Apply one accepted item to the table copies, or queue its pixel if it is a render
  task automatic plasma_step(input plasma_item_t it);
    bit skipped;
    case (it.op)
      OP_LOAD_SINE: begin
        sine_bytes[it.idx] = it.val;
        sine_loads++;
      end
      OP_LOAD_DITHER: begin
        dither_bytes[it.idx[DITHER_AW-1:0]] = it.val;
        dither_loads++;
      end
      OP_RENDER: begin
        expected_pixels.push_back(plasma_pixel(it.x, it.y, it.frame, skipped));
        if (skipped) skip_pixels++;
      end
      default: reserved_items++;
    endcase
  endtask

  function automatic void add_item(input logic [OP_W-1:0] op, input int unsigned idx,
                                   input int unsigned val, input int unsigned x,
                                   input int unsigned y, input int unsigned f);
    plasma_item_t it;
    it.op    = op;
    it.idx   = SINE_AW'(idx);
    it.val   = BYTE_W'(val);
    it.x     = COORD_W'(x);
    it.y     = COORD_W'(y);
    it.frame = FRAME_W'(f);
    pending_items.push_back(it);
  endfunction

  // Table load with pixel fields filled with noise
  function automatic void add_load(input logic [OP_W-1:0] op, input int unsigned idx,
                                   input int unsigned val);
    add_item(op, idx, val, $urandom_range(0, 511), $urandom_range(0, 511),
             $urandom_range(0, 4095));
  endfunction

  // Render with table fields filled with noise
  function automatic void add_render(input int unsigned x, input int unsigned y,
                                     input int unsigned f);
    add_item(OP_RENDER, $urandom_range(0, 1023), $urandom_range(0, 255), x, y, f);
  endfunction

  // Bytes lean toward full scale so the dither skip gets exercised
  function automatic int unsigned high_leaning_byte();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(240, 255) : $urandom_range(0, 255);
  endfunction

  // Frames cluster around the fades and the shift change a quarter of the time
  function automatic int unsigned random_frame();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 4095);
  endfunction

  // Sender: pop items in bursts with random gaps, hold each until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        plasma_step(drive_item);
        items_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          drive_item = pending_items.pop_front();
          in_valid_i     <= 1'b1;
          op_i           <= drive_item.op;
          table_index_i  <= drive_item.idx;
          table_value_i  <= drive_item.val;
          pixel_x_i      <= drive_item.x;
          pixel_y_i      <= drive_item.y;
          frame_number_i <= drive_item.frame;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: switch between stall patterns at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_phase++;
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_ALWAYS:  out_ready_i <= 1'b1;
        RX_MOSTLY:  out_ready_i <= ($urandom_range(0, 3) != 0);
        RX_SPARSE:  out_ready_i <= ($urandom_range(0, 3) == 0);
        default:    out_ready_i <= rx_phase[2];
      endcase
    end
  end

  // Check each delivered pixel against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel: expected none, actual %h", $time, pixel_color_o);
        mismatches++;
      end else begin
        if (pixel_color_o !== expected_pixels[0]) begin
          $display("%0t: pixel mismatch: expected %h, actual %h", $time,
                   expected_pixels[0], pixel_color_o);
          mismatches++;
        end
        void'(expected_pixels.pop_front());
        pixels_checked++;
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned k;
    int unsigned pick;

    // Fill both tables with random bytes before the directed checks
    for (k = 0; k < SINE_DEPTH; k++) add_load(OP_LOAD_SINE, k, high_leaning_byte());
    for (k = 0; k < DITHER_DEPTH; k++) add_load(OP_LOAD_DITHER, k, $urandom_range(0, 255));
    add_load(OP_LOAD_SINE, 1023, 8'h00);
    add_load(OP_LOAD_SINE, 0, 8'hff);
    add_load(OP_LOAD_DITHER, 10'h3ff, 8'h00);
    add_item(OP_RESERVED, 1023, 255, 511, 511, 4095);
    add_item(OP_RESERVED, 0, 0, 0, 0, 0);
    add_render(0, 0, 0);
    add_render(511, 511, 4095);
    add_render(0, 511, 1);
    add_render(511, 0, 63);
    add_render(123, 45, 64);
    add_render(300, 300, 192);
    add_render(77, 410, 193);
    add_render(256, 128, 255);
    add_render(5, 6, 256);
    add_render(510, 1, 2048);

    // Random mix, mostly renders with table updates in between
    repeat (300) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        add_render($urandom_range(0, 511), $urandom_range(0, 511), random_frame());
      end else if (pick < 80) begin
        add_load(OP_LOAD_SINE, $urandom_range(0, 1023), high_leaning_byte());
      end else if (pick < 93) begin
        add_load(OP_LOAD_DITHER, $urandom_range(0, 1023), $urandom_range(0, 255));
      end else begin
        add_item(OP_RESERVED, $urandom_range(0, 1023), $urandom_range(0, 255),
                 $urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 4095));
      end
    end
    total_items = pending_items.size();

    // Hold reset, then release it on a clock edge
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all items in, all pixels out, then let the pipeline settle
    while (items_accepted < total_items) @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d checked pixels (%0d with a skipped dither add) among %0d items,",
             pixels_checked, skip_pixels, items_accepted);
    $display("with %0d sine loads, %0d dither loads and %0d reserved-op items.",
             sine_loads, dither_loads, reserved_items);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
